### hdl/arp_pkg.sv
package arp_pkg;

	localparam int NOTE_W     = 7;
	localparam int NOTE_COUNT = 128;
	localparam int CNT_W      = 8;
	localparam int CH_IN_W    = 4;

	typedef enum logic [1:0] {
		MODE_TICK     = 2'd0,
		MODE_NOTE_ON  = 2'd1,
		MODE_NOTE_OFF = 2'd2,
		MODE_FETCH    = 2'd3
	} arp_mode_t;

	typedef logic [1:0] arp_mark_t;

	localparam arp_mark_t MARK_OFF      = 2'd0;
	localparam arp_mark_t MARK_HELD     = 2'd1;
	localparam arp_mark_t MARK_RELEASED = 2'd2;

	typedef struct packed {
		arp_mode_t            mode;
		logic [NOTE_W-1:0]    note;
		logic [CH_IN_W-1:0]   channel;
	} arp_in_t;

	typedef struct packed {
		logic [NOTE_W-1:0]    next_note;
		logic [CNT_W-1:0]     held_notes;
	} arp_out_t;

	// controller to datapath
	typedef struct packed {
		logic note_on;
		logic note_off;
		logic tick_go;
		logic fetch_go;
		logic run;
		logic fetch_out;
	} arp_ctl_t;

	// datapath to controller
	typedef struct packed {
		logic count_one;
		logic scan_done;
	} arp_sts_t;

endpackage

### hdl/auto_arpeggio_note_selector.sv
// Up-arpeggiator note picker. An item is taken when start is high and busy is low.
// A note-off is done in the accept cycle and never raises busy. A tick while the
// held count is one is likewise done at once. Any other tick scans the note marks
// upward from the pointer, one mark per cycle through the single read port of the
// mark memory, and holds busy until the first held note is found or every mark has
// been scanned. A note-on recounts all 128 marks the same way and holds busy until
// the last mark is counted. A fetch holds busy while in the fetch state; its result
// shows on result with done high for a single cycle, registered from the fetch
// state, and is taken at the edge that ends that cycle since the block
// cannot be stalled. Mark and pending-note storage come out of reset cleared, with
// no start-up sweep.
module auto_arpeggio_note_selector #(
	parameter int CHANNELS = 16
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  arp_pkg::arp_in_t  cmd,
	output logic              done,
	output arp_pkg::arp_out_t result
);
	import arp_pkg::*;

	arp_ctl_t ctl;
	arp_sts_t sts;

	arp_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.mode   (cmd.mode),
		.sts    (sts),
		.busy   (busy),
		.ctl    (ctl)
	);

	arp_dp #(
		.CHANNELS (CHANNELS)
	) u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd),
		.ctl    (ctl),
		.sts    (sts),
		.done   (done),
		.result (result)
	);

endmodule

### hdl/arp_ram.sv
module arp_ram #(
	parameter int WIDTH = 2,
	parameter int DEPTH = 128,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rd_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rd_q <= mem_q[raddr];
	end

	assign rdata = rd_q;

endmodule

### hdl/arp_ctrl.sv
module arp_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  arp_pkg::arp_mode_t mode,
	input  arp_pkg::arp_sts_t  sts,
	output logic               busy,
	output arp_pkg::arp_ctl_t  ctl
);
	import arp_pkg::*;

	typedef enum logic [1:0] {
		S_IDLE,
		S_RUN,
		S_FETCH
	} state_t;

	state_t state_q;
	logic   accept;

	assign accept = start && (state_q == S_IDLE);
	assign busy   = (state_q != S_IDLE);

	always_comb begin
		ctl = '0;
		if (accept) begin
			unique case (mode)
				MODE_TICK:     ctl.tick_go  = !sts.count_one;
				MODE_NOTE_ON:  ctl.note_on  = 1'b1;
				MODE_NOTE_OFF: ctl.note_off = 1'b1;
				MODE_FETCH:    ctl.fetch_go = 1'b1;
				default:       ctl = '0;
			endcase
		end
		ctl.run       = (state_q == S_RUN);
		ctl.fetch_out = (state_q == S_FETCH);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (ctl.note_on || ctl.tick_go) begin
						state_q <= S_RUN;
					end else if (ctl.fetch_go) begin
						state_q <= S_FETCH;
					end
				end
				S_RUN: begin
					if (sts.scan_done) begin
						state_q <= S_IDLE;
					end
				end
				S_FETCH: state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end

	a_run_ends: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_RUN) && sts.scan_done |=> (state_q == S_IDLE))
		else $error("scan did not return to idle");

	a_fetch_one: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_FETCH) |=> (state_q == S_IDLE))
		else $error("fetch state held more than one cycle");

endmodule

### hdl/arp_dp.sv
module arp_dp #(
	parameter int CHANNELS = 16
) (
	input  logic              clk,
	input  logic              arst_n,
	input  arp_pkg::arp_in_t  cmd,
	input  arp_pkg::arp_ctl_t ctl,
	output arp_pkg::arp_sts_t sts,
	output logic              done,
	output arp_pkg::arp_out_t result
);
	import arp_pkg::*;

	localparam int CH_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

	logic [NOTE_W-1:0]   ptr_q;
	logic [CNT_W-1:0]    held_cnt_q;
	logic [CNT_W-1:0]    acc_q;
	logic                tick_q;
	logic [CH_W-1:0]     ch_addr_q;
	logic                ch_ok_q;
	logic [NOTE_W-1:0]   iss_q;
	logic [CNT_W-1:0]    icnt_q;
	logic [NOTE_W-1:0]   ecnt_q;
	logic                vld_s1;
	logic [NOTE_W-1:0]   addr_s1;
	logic                mval_s1;
	logic                fv_s1;
	logic [NOTE_COUNT-1:0] mvalid_q;
	logic [CHANNELS-1:0] pvalid_q;
	logic                done_q;
	arp_out_t            result_q;

	arp_mark_t         mark_rd;
	arp_mark_t         mark_eff;
	logic [NOTE_W-1:0] pend_rd;
	logic [CH_W-1:0]   ch_addr_in;
	logic              ch_ok_in;
	logic              issue;
	logic              eval;
	logic              hit;
	logic              last;
	logic              finish;
	logic              pend_we;
	logic [CNT_W-1:0]  held_inc;

	assign ch_addr_in = CH_W'(cmd.channel);
	assign ch_ok_in   = int'(cmd.channel) < CHANNELS;

	// a mark whose valid bit is clear reads as off
	assign mark_eff = mval_s1 ? mark_rd : MARK_OFF;
	assign issue    = ctl.run && (icnt_q < CNT_W'(NOTE_COUNT));
	assign eval     = ctl.run && vld_s1;
	assign hit      = tick_q && (mark_eff == MARK_HELD);
	assign last     = (ecnt_q == NOTE_W'(NOTE_COUNT - 1));
	assign finish   = eval && (hit || last);
	assign pend_we  = eval && hit && ch_ok_q;
	assign held_inc = CNT_W'(mark_eff == MARK_HELD);

	assign sts.scan_done = finish;
	assign sts.count_one = (held_cnt_q == CNT_W'(1));

	arp_ram #(
		.WIDTH ($bits(arp_mark_t)),
		.DEPTH (NOTE_COUNT)
	) u_mark_ram (
		.clk   (clk),
		.we    (ctl.note_on || ctl.note_off),
		.waddr (cmd.note),
		.wdata (ctl.note_on ? MARK_HELD : MARK_RELEASED),
		.raddr (iss_q),
		.rdata (mark_rd)
	);

	arp_ram #(
		.WIDTH (NOTE_W),
		.DEPTH (CHANNELS)
	) u_pend_ram (
		.clk   (clk),
		.we    (pend_we),
		.waddr (ch_addr_q),
		.wdata (addr_s1),
		.raddr (ch_addr_in),
		.rdata (pend_rd)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ptr_q      <= '0;
			held_cnt_q <= '0;
			acc_q      <= '0;
			tick_q     <= 1'b0;
			ch_addr_q  <= '0;
			ch_ok_q    <= 1'b0;
			iss_q      <= '0;
			icnt_q     <= '0;
			ecnt_q     <= '0;
			vld_s1     <= 1'b0;
			addr_s1    <= '0;
			mval_s1    <= 1'b0;
			fv_s1      <= 1'b0;
			mvalid_q   <= '0;
			pvalid_q   <= '0;
			done_q     <= 1'b0;
			result_q   <= '0;
		end else begin
			done_q <= ctl.fetch_out;
			if (ctl.fetch_out) begin
				result_q.next_note  <= fv_s1 ? pend_rd : '0;
				result_q.held_notes <= held_cnt_q;
			end

			// fetch reads the slot and empties it
			if (ctl.fetch_go) begin
				fv_s1 <= ch_ok_in && pvalid_q[ch_addr_in];
				if (ch_ok_in) begin
					pvalid_q[ch_addr_in] <= 1'b0;
				end
			end

			if (ctl.note_on || ctl.note_off) begin
				mvalid_q[cmd.note] <= 1'b1;
			end
			if (ctl.note_on) begin
				ptr_q <= cmd.note;
			end

			if (ctl.note_on || ctl.tick_go) begin
				tick_q    <= ctl.tick_go;
				ch_addr_q <= ch_addr_in;
				ch_ok_q   <= ch_ok_in;
				iss_q     <= ctl.tick_go ? ptr_q + NOTE_W'(1) : '0;
				icnt_q    <= '0;
				ecnt_q    <= '0;
				acc_q     <= '0;
				vld_s1    <= 1'b0;
			end else begin
				vld_s1 <= issue;
				if (issue) begin
					iss_q   <= iss_q + NOTE_W'(1);
					icnt_q  <= icnt_q + CNT_W'(1);
					addr_s1 <= iss_q;
					mval_s1 <= mvalid_q[iss_q];
				end
				if (eval) begin
					ecnt_q <= ecnt_q + NOTE_W'(1);
					if (tick_q) begin
						if (mark_eff == MARK_RELEASED) begin
							mvalid_q[addr_s1] <= 1'b0;
						end
						// no held note leaves the pointer back at its start
						if (finish) begin
							ptr_q <= addr_s1;
						end
						if (pend_we) begin
							pvalid_q[ch_addr_q] <= 1'b1;
						end
					end else begin
						acc_q <= acc_q + held_inc;
						if (last) begin
							held_cnt_q <= acc_q + held_inc;
						end
					end
				end
			end
		end
	end

	assign done   = done_q;
	assign result = result_q;

	a_fetch_latency: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.fetch_go |-> ##2 done)
		else $error("fetch result not delivered two cycles after accept");

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		held_cnt_q <= CNT_W'(NOTE_COUNT))
		else $error("held count out of range");

	a_count_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		eval && last && !tick_q |=> (held_cnt_q != '0))
		else $error("recount after note on found no held note");

endmodule

### tb/sv/arp_check_pkg.sv
`timescale 1ns / 100ps
package arp_check_pkg;

	import arp_pkg::*;

	localparam int TB_CHANNELS = 16;

	class arpeggio_tracker;
		arp_mark_t         marks [NOTE_COUNT];
		logic [NOTE_W-1:0] pointer;
		logic [CNT_W-1:0]  held;
		logic [NOTE_W-1:0] latched [TB_CHANNELS];
		arp_out_t          fetch_due [$];
		int                errors;

		function new();
			foreach (marks[i]) marks[i] = MARK_OFF;
			foreach (latched[i]) latched[i] = '0;
			pointer = '0;
			held = '0;
			errors = 0;
		endfunction

		// upward scan with wrap, released marks cleared on the way
		function void tick_scan(logic [CH_IN_W-1:0] ch);
			logic [NOTE_W-1:0] p;
			if (held == 8'd1)
				return;
			p = pointer;
			for (int k = 0; k < NOTE_COUNT; k++) begin
				p = p + 1'b1;
				if (marks[p] == MARK_HELD) begin
					if (ch < TB_CHANNELS)
						latched[ch] = p;
					break;
				end
				if (marks[p] == MARK_RELEASED)
					marks[p] = MARK_OFF;
			end
			pointer = p;
		endfunction

		function void note_on_recount(logic [NOTE_W-1:0] n);
			logic [CNT_W-1:0] cnt;
			marks[n] = MARK_HELD;
			pointer = n;
			cnt = '0;
			foreach (marks[i])
				if (marks[i] == MARK_HELD)
					cnt++;
			held = cnt;
		endfunction

		function void apply_item(arp_in_t item);
			arp_out_t res;
			case (item.mode)
				MODE_TICK: tick_scan(item.channel);
				MODE_NOTE_ON: note_on_recount(item.note);
				MODE_NOTE_OFF: marks[item.note] = MARK_RELEASED;
				MODE_FETCH: begin
					res.next_note = '0;
					if (item.channel < TB_CHANNELS) begin
						res.next_note = latched[item.channel];
						latched[item.channel] = '0;
					end
					res.held_notes = held;
					fetch_due.push_back(res);
				end
			endcase
		endfunction

		function void check_fetch(arp_out_t got);
			arp_out_t want;
			if (fetch_due.size() == 0) begin
				$error("result with nothing due: next_note %0d held_notes %0d",
					got.next_note, got.held_notes);
				errors++;
				return;
			end
			want = fetch_due.pop_front();
			if (got.next_note !== want.next_note) begin
				$error("next_note: expected %0d, actual %0d", want.next_note, got.next_note);
				errors++;
			end
			if (got.held_notes !== want.held_notes) begin
				$error("held_notes: expected %0d, actual %0d", want.held_notes,
					got.held_notes);
				errors++;
			end
		endfunction
	endclass

endpackage

### tb/sv/testbench.sv
`timescale 1ns / 100ps
module testbench;

	import arp_pkg::*;
	import arp_check_pkg::*;

	logic     clk = 1'b0;
	logic     arst_n = 1'b0;
	logic     start = 1'b0;
	arp_in_t  cmd = '0;
	logic     busy;
	logic     done;
	arp_out_t result;

	arpeggio_tracker tracker = new();

	int                burst_left = 0;
	bit                calm = 1'b0;
	int                items_sent = 0;
	logic [NOTE_W-1:0] window_base = '0;

	auto_arpeggio_note_selector #(.CHANNELS(TB_CHANNELS)) uut (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.cmd    (cmd),
		.done   (done),
		.result (result)
	);

	always #5 clk = ~clk;

	// result checked before the same-edge item is noted
	always @(posedge clk) begin
		if (arst_n) begin
			if (done === 1'b1)
				tracker.check_fetch(result);
			if (start === 1'b1 && busy === 1'b0)
				tracker.apply_item(cmd);
		end
	end

	task automatic issue(arp_in_t item);
		@(negedge clk);
		start <= 1'b1;
		cmd <= item;
		do
			@(posedge clk);
		while (busy !== 1'b0);
		items_sent++;
	endtask

	task automatic pause(int n);
		if (n == 0)
			return;
		@(negedge clk);
		start <= 1'b0;
		repeat (n - 1) @(negedge clk);
	endtask

	// bursts of items with random gaps, some stretches with no gaps at all
	task automatic send(arp_in_t item);
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 24);
			if (!calm)
				pause(($urandom_range(0, 3) == 0) ? $urandom_range(20, 140) :
					$urandom_range(1, 6));
			calm = ($urandom_range(0, 3) == 0);
		end
		burst_left--;
		issue(item);
	endtask

	task automatic send_op(arp_mode_t m, int n, int ch);
		arp_in_t item;
		item.mode = m;
		item.note = n[NOTE_W-1:0];
		item.channel = ch[CH_IN_W-1:0];
		send(item);
	endtask

	function automatic logic [NOTE_W-1:0] window_note();
		return window_base + NOTE_W'($urandom_range(0, 7));
	endfunction

	function automatic int pick_channel(int seq_ch);
		return ($urandom_range(0, 3) == 0) ? $urandom_range(0, 15) : seq_ch;
	endfunction

	initial begin
		int seq_ch;
		repeat (6) @(negedge clk);
		arst_n <= 1'b1;

		// directed: reset state, count of one, wrap, ambiguous zero, stale count
		send_op(MODE_FETCH, $urandom_range(0, 127), 0);
		send_op(MODE_TICK, $urandom_range(0, 127), 15);
		send_op(MODE_NOTE_ON, 127, $urandom_range(0, 15));
		send_op(MODE_TICK, $urandom_range(0, 127), 1);
		send_op(MODE_FETCH, $urandom_range(0, 127), 1);
		send_op(MODE_NOTE_ON, 0, $urandom_range(0, 15));
		send_op(MODE_TICK, $urandom_range(0, 127), 5);
		send_op(MODE_FETCH, $urandom_range(0, 127), 5);
		send_op(MODE_TICK, $urandom_range(0, 127), 15);
		send_op(MODE_FETCH, $urandom_range(0, 127), 15);
		send_op(MODE_NOTE_OFF, 127, $urandom_range(0, 15));
		send_op(MODE_TICK, $urandom_range(0, 127), 3);
		send_op(MODE_NOTE_OFF, 0, $urandom_range(0, 15));
		send_op(MODE_TICK, $urandom_range(0, 127), 7);
		send_op(MODE_FETCH, $urandom_range(0, 127), 7);
		send_op(MODE_FETCH, $urandom_range(0, 127), 3);
		send_op(MODE_NOTE_OFF, 85, 0);
		send_op(MODE_NOTE_ON, 42, 15);
		send_op(MODE_TICK, $urandom_range(0, 127), 9);
		send_op(MODE_NOTE_ON, 85, $urandom_range(0, 15));
		send_op(MODE_TICK, $urandom_range(0, 127), 9);
		send_op(MODE_FETCH, 0, 9);
		send_op(MODE_FETCH, 127, 9);

		// random: note events inside a moving window, then ticks and fetches
		while (items_sent < 680) begin
			if ($urandom_range(0, 3) == 0)
				window_base = NOTE_W'($urandom_range(0, 127));
			seq_ch = $urandom_range(0, 15);
			case ($urandom_range(0, 9))
				0, 1, 2, 3: begin
					repeat ($urandom_range(1, 5))
						send_op(MODE_NOTE_ON, int'(window_note()), $urandom_range(0, 15));
				end
				4, 5, 6: begin
					repeat ($urandom_range(1, 6))
						send_op(MODE_NOTE_OFF, int'(window_note()), $urandom_range(0, 15));
				end
				7: begin
					repeat ($urandom_range(1, 8))
						send_op(arp_mode_t'($urandom_range(0, 3)), $urandom_range(0, 127),
							$urandom_range(0, 15));
				end
				default: ;
			endcase
			repeat ($urandom_range(1, 8)) begin
				if ($urandom_range(0, 2) == 0)
					send_op(MODE_FETCH, $urandom_range(0, 127), pick_channel(seq_ch));
				else
					send_op(MODE_TICK, $urandom_range(0, 127), pick_channel(seq_ch));
			end
		end

		// every note held, so the count reaches its top
		for (int n = 0; n < NOTE_COUNT; n++)
			send_op(MODE_NOTE_ON, n, $urandom_range(0, 15));
		send_op(MODE_FETCH, $urandom_range(0, 127), 2);
		send_op(MODE_TICK, $urandom_range(0, 127), 2);
		send_op(MODE_FETCH, $urandom_range(0, 127), 2);
		send_op(MODE_TICK, $urandom_range(0, 127), 11);
		send_op(MODE_FETCH, $urandom_range(0, 127), 11);

		@(negedge clk);
		start <= 1'b0;
		while (tracker.fetch_due.size() != 0)
			@(posedge clk);
		repeat (140) @(posedge clk);
		if (tracker.errors == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

	initial begin
		#10_000_000;
		$display("*** FAILED ***");
		$finish;
	end

endmodule

### files.f
hdl/arp_pkg.sv
hdl/arp_ram.sv
hdl/arp_ctrl.sv
hdl/arp_dp.sv
hdl/auto_arpeggio_note_selector.sv
tb/sv/arp_check_pkg.sv
tb/sv/testbench.sv
